/* sv/preferential_attachment_graph_gen_core_macros.svh */
// Assertion macros for the preferential attachment graph generator
`ifndef PREFERENTIAL_ATTACHMENT_GRAPH_GEN_CORE_MACROS_SVH
`define PREFERENTIAL_ATTACHMENT_GRAPH_GEN_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PAGG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PAGG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pagg_pkg.sv */
// Shared types, codes and constants of the preferential attachment graph generator
package pagg_pkg;

    localparam int NODES_W      = 11;
    localparam int LINKS_W      = 4;
    localparam int NODE_FIELD_W = 10;
    localparam int RANDOM_W     = 31;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_INDEX_W  = 1;

    localparam int DEF_MAX_NODES   = 1024;
    localparam int DEF_MAX_LINKS   = 8;
    localparam int DEF_RANDOM_BITS = 31;

    localparam logic [NODES_W-1:0] RESET_NODES_TOTAL    = 11'd64;
    localparam logic [LINKS_W-1:0] RESET_LINKS_PER_NODE = 4'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_NODES_TOTAL    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINKS_PER_NODE = 1'b1;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DRAW  = 1'b1;

    typedef enum logic [2:0] {
        ST_SEED      = 3'd0,
        ST_ACCEPTED  = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FINISHED  = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED_A,
        S_SEED_B,
        S_DIV,
        S_READ,
        S_CHECK,
        S_APPEND
    } state_t;

    typedef struct packed {
        logic                command;
        logic [RANDOM_W-1:0] random_value;
    } pagg_in_t;

    typedef struct packed {
        logic [NODE_FIELD_W-1:0] from_node;
        logic [NODE_FIELD_W-1:0] to_node;
        status_t                 status;
        logic                    last;
    } pagg_out_t;

endpackage

/* sv/preferential_attachment_graph_gen_core.sv */
// Top level of the preferential attachment graph generator
// A draw runs the bit-serial modulo on one subtract/compare unit (S_DIV), then the list read,
//   the check and, unless the target is a duplicate, the append; a start writes each seed edge
//   in S_SEED_A and S_SEED_B; reports and a one-node clique are answered from idle directly.
// Throughput: one item at a time; the next transfer lands with or after the final result;
//   the receiver cannot stall.
// Reset clears control state and sets nodes_total 64, links_per_node 2; the endpoint list
//   RAM is not cleared and needs no clearing pass.
module preferential_attachment_graph_gen_core
    import pagg_pkg::*;
#(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int MAX_LINKS   = DEF_MAX_LINKS,
    parameter int RANDOM_BITS = DEF_RANDOM_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  pagg_in_t               item,
    output logic                   busy,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   result_valid,
    output pagg_out_t              result
);

    localparam int MAX_ID     = (MAX_NODES > MAX_LINKS) ? MAX_NODES : MAX_LINKS;
    localparam int ID_W       = $clog2(MAX_ID);
    localparam int NODE_W     = $clog2(MAX_ID + 1);
    localparam int LIST_DEPTH = 2 * MAX_LINKS * MAX_NODES;
    localparam int AW         = $clog2(LIST_DEPTH);
    localparam int LEN_W      = $clog2(LIST_DEPTH + 1);
    localparam int CNT_W      = $clog2(MAX_LINKS + 1);
    localparam int CH_W       = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam int RB         = (RANDOM_BITS < RANDOM_W) ? RANDOM_BITS : RANDOM_W;
    localparam int BIT_W      = $clog2(RB);

    state_t              state_reg, state_next;
    logic [NODES_W-1:0]  nodes_reg, nodes_next;
    logic [LINKS_W-1:0]  links_reg, links_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [NODE_W-1:0]   current_reg, current_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                started_reg, started_next;
    logic [CNT_W-1:0]    seed_i_reg, seed_i_next;
    logic [CNT_W-1:0]    seed_j_reg, seed_j_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [LEN_W-1:0]    rem_reg, rem_next;
    logic [RB-1:0]       dividend_reg, dividend_next;
    logic [ID_W-1:0]     target_reg, target_next;
    logic [ID_W-1:0]     chosen_reg [MAX_LINKS];
    logic [ID_W-1:0]     chosen_next [MAX_LINKS];
    logic                result_valid_reg, result_valid_next;
    pagg_out_t           result_reg, result_next;

    logic                accept;
    logic [CNT_W-1:0]    m_eff;
    logic [NODE_W-1:0]   n_eff;
    logic                seed_last;
    logic                len_room;
    logic                dup_hit;
    logic [LEN_W:0]      div_trial;
    logic [LEN_W:0]      div_rem;
    logic [CNT_W-1:0]    count_inc;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ID_W-1:0]     ram_wdata;
    logic [ID_W-1:0]     ram_rdata;

    function automatic pagg_out_t pack_result(
        logic [NODE_FIELD_W-1:0] from_id,
        logic [NODE_FIELD_W-1:0] to_id,
        status_t                 code,
        logic                    fin
    );
        pagg_out_t r;
        r.from_node = from_id;
        r.to_node   = to_id;
        r.status    = code;
        r.last      = fin;
        return r;
    endfunction

    pagg_ram #(
        .WIDTH (ID_W),
        .DEPTH (LIST_DEPTH)
    ) u_list (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rem_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign busy         = (state_reg != S_IDLE);
    assign accept       = start && !busy;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        if (links_reg == '0)
        begin
            m_eff = CNT_W'(1);
        end
        else if (int'(links_reg) > MAX_LINKS)
        begin
            m_eff = CNT_W'(MAX_LINKS);
        end
        else
        begin
            m_eff = CNT_W'(links_reg);
        end

        if (nodes_reg == '0)
        begin
            n_eff = NODE_W'(1);
        end
        else if (int'(nodes_reg) > MAX_NODES)
        begin
            n_eff = NODE_W'(MAX_NODES);
        end
        else
        begin
            n_eff = NODE_W'(nodes_reg);
        end
    end

    assign seed_last = (seed_i_reg == m_eff - CNT_W'(2)) && (seed_j_reg == m_eff - CNT_W'(1));
    assign len_room  = (len_reg < LEN_W'(LIST_DEPTH));
    assign div_trial = {rem_reg, dividend_reg[RB-1]};
    assign div_rem   = (div_trial >= {1'b0, len_reg}) ? div_trial - {1'b0, len_reg} : div_trial;
    assign count_inc = count_reg + CNT_W'(1);

    always_comb
    begin
        dup_hit = 1'b0;
        for (int k = 0; k < MAX_LINKS; k++)
        begin
            if ((CNT_W'(k) < count_reg) && (chosen_reg[k] == ram_rdata))
            begin
                dup_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        nodes_next = nodes_reg;
        links_next = links_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NODES_TOTAL:    nodes_next = cfg_data;
                REG_LINKS_PER_NODE: links_next = cfg_data[LINKS_W-1:0];
                default:            nodes_next = nodes_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.command == CMD_START)
                    begin
                        state_next = (m_eff == CNT_W'(1)) ? S_IDLE : S_SEED_A;
                    end
                    else if (!started_reg || (current_reg >= n_eff) || (len_reg == '0))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_SEED_A: state_next = S_SEED_B;
            S_SEED_B: state_next = seed_last ? S_IDLE : S_SEED_A;
            S_DIV:    state_next = (bit_reg == '0) ? S_READ : S_DIV;
            S_READ:   state_next = S_CHECK;
            S_CHECK:  state_next = dup_hit ? S_IDLE : S_APPEND;
            S_APPEND: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        len_next          = len_reg;
        current_next      = current_reg;
        count_next        = count_reg;
        started_next      = started_reg;
        seed_i_next       = seed_i_reg;
        seed_j_next       = seed_j_reg;
        bit_next          = bit_reg;
        rem_next          = rem_reg;
        dividend_next     = dividend_reg;
        target_next       = target_reg;
        chosen_next       = chosen_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        ram_we            = 1'b0;
        ram_waddr         = len_reg[AW-1:0];
        ram_wdata         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.command == CMD_START))
                begin
                    len_next     = '0;
                    count_next   = '0;
                    current_next = NODE_W'(m_eff);
                    started_next = 1'b1;
                    seed_i_next  = '0;
                    seed_j_next  = CNT_W'(1);
                    if (m_eff == CNT_W'(1))
                    begin
                        result_valid_next = 1'b1;
                        result_next       = pack_result('0, '0, ST_EMPTY, 1'b1);
                    end
                end
                else if (accept)
                begin
                    if (!started_reg)
                    begin
                        result_valid_next = 1'b1;
                        result_next       = pack_result('0, '0, ST_EMPTY, 1'b1);
                    end
                    else if (current_reg >= n_eff)
                    begin
                        result_valid_next = 1'b1;
                        result_next       = pack_result('0, '0, ST_FINISHED, 1'b1);
                    end
                    else if (len_reg == '0)
                    begin
                        result_valid_next = 1'b1;
                        result_next       = pack_result('0, '0, ST_EMPTY, 1'b1);
                    end
                    else
                    begin
                        dividend_next = item.random_value[RB-1:0];
                        rem_next      = '0;
                        bit_next      = BIT_W'(RB - 1);
                    end
                end
            end
            S_SEED_A:
            begin
                ram_we    = len_room;
                ram_wdata = ID_W'(seed_i_reg);
                if (len_room)
                begin
                    len_next = len_reg + LEN_W'(1);
                end
            end
            S_SEED_B:
            begin
                ram_we    = len_room;
                ram_wdata = ID_W'(seed_j_reg);
                if (len_room)
                begin
                    len_next = len_reg + LEN_W'(1);
                end
                result_valid_next = 1'b1;
                result_next       = pack_result(NODE_FIELD_W'(seed_i_reg),
                                                NODE_FIELD_W'(seed_j_reg), ST_SEED, seed_last);
                if (seed_j_reg == m_eff - CNT_W'(1))
                begin
                    seed_i_next = seed_i_reg + CNT_W'(1);
                    seed_j_next = seed_i_reg + CNT_W'(2);
                end
                else
                begin
                    seed_j_next = seed_j_reg + CNT_W'(1);
                end
            end
            S_DIV:
            begin
                rem_next      = div_rem[LEN_W-1:0];
                dividend_next = dividend_reg << 1;
                bit_next      = bit_reg - BIT_W'(1);
            end
            S_READ:
            begin
                target_next = target_reg;
            end
            S_CHECK:
            begin
                target_next = ram_rdata;
                if (dup_hit)
                begin
                    result_valid_next = 1'b1;
                    result_next       = pack_result(NODE_FIELD_W'(current_reg),
                                                    NODE_FIELD_W'(ram_rdata), ST_DUPLICATE, 1'b1);
                end
                else
                begin
                    ram_we    = len_room;
                    ram_wdata = ID_W'(current_reg);
                    if (len_room)
                    begin
                        len_next = len_reg + LEN_W'(1);
                    end
                end
            end
            S_APPEND:
            begin
                ram_we    = len_room;
                ram_wdata = target_reg;
                if (len_room)
                begin
                    len_next = len_reg + LEN_W'(1);
                end
                result_valid_next = 1'b1;
                result_next       = pack_result(NODE_FIELD_W'(current_reg),
                                                NODE_FIELD_W'(target_reg), ST_ACCEPTED, 1'b1);
                if (count_reg < CNT_W'(MAX_LINKS))
                begin
                    chosen_next[count_reg[CH_W-1:0]] = target_reg;
                    count_next                       = count_inc;
                end
                if (((count_reg < CNT_W'(MAX_LINKS)) ? count_inc : count_reg) >= m_eff)
                begin
                    count_next   = '0;
                    current_next = current_reg + NODE_W'(1);
                end
            end
            default:
            begin
                result_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            nodes_reg        <= RESET_NODES_TOTAL;
            links_reg        <= RESET_LINKS_PER_NODE;
            len_reg          <= '0;
            current_reg      <= '0;
            count_reg        <= '0;
            started_reg      <= 1'b0;
            seed_i_reg       <= '0;
            seed_j_reg       <= '0;
            bit_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            nodes_reg        <= nodes_next;
            links_reg        <= links_next;
            len_reg          <= len_next;
            current_reg      <= current_next;
            count_reg        <= count_next;
            started_reg      <= started_next;
            seed_i_reg       <= seed_i_next;
            seed_j_reg       <= seed_j_next;
            bit_reg          <= bit_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        dividend_reg <= dividend_next;
        target_reg   <= target_next;
        chosen_reg   <= chosen_next;
        result_reg   <= result_next;
    end

endmodule

/* sv/pagg_ram.sv */
// Generic single-port-write, registered-read RAM
module pagg_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/pagg_checker.sv */
// Port-level checker for the graph generator core, bound to the top level
`include "preferential_attachment_graph_gen_core_macros.svh"

module pagg_checker
    import pagg_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      result_valid,
    input pagg_out_t result
);

    `PAGG_ASSERT_NEXT(a_accept_answers, start && !busy, busy || result_valid, "transfer neither started work nor answered")
    `PAGG_ASSERT_NOW(a_last_frees, result_valid && result.last, !busy, "busy still high on final result")
    `PAGG_ASSERT_NOW(a_mid_busy, result_valid && !result.last, busy, "idle before final result")
    `PAGG_ASSERT_NOW(a_seed_order, result_valid && (result.status == ST_SEED), result.from_node < result.to_node, "seed edge out of order")
    `PAGG_ASSERT_NOW(a_report_zero, result_valid && ((result.status == ST_FINISHED) || (result.status == ST_EMPTY)), (result.from_node == '0) && (result.to_node == '0) && result.last, "report result carries nodes")

endmodule

bind preferential_attachment_graph_gen_core pagg_checker u_pagg_checker (.*);

/* bench/testbench.sv */
// Self-checking testbench for the preferential attachment graph generator core
module testbench
    import pagg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH  = 2 * DEF_MAX_LINKS * DEF_MAX_NODES;
    localparam int CYCLE_LIMIT = 400000;

    bit                      clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    pagg_in_t                cmd_item = '0;
    logic                    busy;
    logic                    cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    result_valid;
    pagg_out_t               result;

    // predictor state
    logic [NODES_W-1:0]      cfg_nodes = RESET_NODES_TOTAL;
    logic [LINKS_W-1:0]      cfg_links = RESET_LINKS_PER_NODE;
    logic [NODE_FIELD_W-1:0] ep_list [LIST_DEPTH];
    logic [14:0]             ep_count = '0;
    logic [NODES_W-1:0]      node_now = '0;
    logic [NODE_FIELD_W-1:0] picked [DEF_MAX_LINKS];
    logic [LINKS_W-1:0]      picked_n = '0;
    bit                      seeded = 1'b0;

    pagg_out_t               pending_edges [$];
    int                      n_fail = 0;
    int                      cycles = 0;

    preferential_attachment_graph_gen_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (cmd_item),
        .busy         (busy),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int links_eff();
        if (cfg_links == 0)
            return 1;
        if (cfg_links > DEF_MAX_LINKS)
            return DEF_MAX_LINKS;
        return int'(cfg_links);
    endfunction

    function automatic int nodes_eff();
        if (cfg_nodes == 0)
            return 1;
        if (cfg_nodes > DEF_MAX_NODES)
            return DEF_MAX_NODES;
        return int'(cfg_nodes);
    endfunction

    function automatic void add_expected(logic [NODE_FIELD_W-1:0] f,
                                         logic [NODE_FIELD_W-1:0] t,
                                         status_t s, logic l);
        pagg_out_t e;
        e.from_node = f;
        e.to_node   = t;
        e.status    = s;
        e.last      = l;
        pending_edges = {pending_edges, e};
    endfunction

    function automatic void push_endpoint(logic [NODE_FIELD_W-1:0] v);
        if (ep_count < LIST_DEPTH)
        begin
            ep_list[ep_count] = v;
            ep_count++;
        end
    endfunction

    function automatic void predict_item(pagg_in_t it);
        int          m;
        int          n;
        int          i;
        int          j;
        bit          hit;
        int unsigned idx;
        logic [NODE_FIELD_W-1:0] tgt;
        m = links_eff();
        n = nodes_eff();
        if (it.command == CMD_START)
        begin
            ep_count = '0;
            picked_n = '0;
            node_now = NODES_W'(m);
            seeded   = 1'b1;
            for (i = 0; i < m; i++)
                for (j = i + 1; j < m; j++)
                begin
                    push_endpoint(NODE_FIELD_W'(i));
                    push_endpoint(NODE_FIELD_W'(j));
                    add_expected(NODE_FIELD_W'(i), NODE_FIELD_W'(j), ST_SEED,
                                 (i == m - 2) && (j == m - 1));
                end
            if (m == 1)
                add_expected('0, '0, ST_EMPTY, 1'b1);
        end
        else if (!seeded)
            add_expected('0, '0, ST_EMPTY, 1'b1);
        else if (node_now >= n)
            add_expected('0, '0, ST_FINISHED, 1'b1);
        else if (ep_count == 0)
            add_expected('0, '0, ST_EMPTY, 1'b1);
        else
        begin
            idx = int'(it.random_value) % int'(ep_count);
            tgt = ep_list[idx];
            hit = 1'b0;
            for (i = 0; i < picked_n; i++)
                if (picked[i] == tgt)
                    hit = 1'b1;
            if (hit)
                add_expected(node_now[NODE_FIELD_W-1:0], tgt, ST_DUPLICATE, 1'b1);
            else
            begin
                add_expected(node_now[NODE_FIELD_W-1:0], tgt, ST_ACCEPTED, 1'b1);
                push_endpoint(node_now[NODE_FIELD_W-1:0]);
                push_endpoint(tgt);
                if (picked_n < DEF_MAX_LINKS)
                begin
                    picked[picked_n] = tgt;
                    picked_n++;
                end
                if (picked_n >= m)
                begin
                    picked_n = '0;
                    node_now++;
                end
            end
        end
    endfunction

    function automatic logic [RANDOM_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return RANDOM_W'($urandom_range(0, 63));
            default: return RANDOM_W'($urandom);
        endcase
    endfunction

    function automatic void compare_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        pagg_out_t want;
        if (rst_n && result_valid)
        begin
            if (pending_edges.size() == 0)
            begin
                $error("result with no transfer pending: from %0d to %0d status %0d",
                       result.from_node, result.to_node, result.status);
                n_fail++;
            end
            else
            begin
                want = pending_edges.pop_front();
                compare_field("from_node", int'(want.from_node), int'(result.from_node));
                compare_field("to_node", int'(want.to_node), int'(result.to_node));
                compare_field("status", int'(want.status), int'(result.status));
                compare_field("last", int'(want.last), int'(result.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // hold the item until the transfer, then insert a random gap
    task automatic send_item(input logic cmd, input logic [RANDOM_W-1:0] rv);
        pagg_in_t it;
        int       r;
        int       gap;
        it.command      = cmd;
        it.random_value = rv;
        start    <= 1'b1;
        cmd_item <= it;
        do
            @(posedge clk);
        while (busy);
        predict_item(it);
        r = $urandom_range(0, 15);
        if (r < 8)
            gap = 0;
        else if (r < 14)
            gap = $urandom_range(1, 4);
        else
            gap = $urandom_range(10, 70);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_edges.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_NODES_TOTAL)
            cfg_nodes = data[NODES_W-1:0];
        else
            cfg_links = data[LINKS_W-1:0];
        @(posedge clk);
    endtask

    // wait for the block to go idle, then write both registers
    task automatic set_config(input int nv, input int lv);
        drain();
        while (busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
        write_reg(REG_NODES_TOTAL, CFG_DATA_W'(nv));
        write_reg(REG_LINKS_PER_NODE, {7'($urandom), LINKS_W'(lv)});
    endtask

    task automatic test_draw_before_start();
        send_item(CMD_DRAW, '0);
        send_item(CMD_DRAW, '1);
    endtask

    task automatic test_reset_defaults();
        int k;
        send_item(CMD_START, rand_word());
        send_item(CMD_DRAW, '0);
        send_item(CMD_DRAW, '1);
        for (k = 0; k < 4; k++)
            send_item(CMD_DRAW, rand_word());
    endtask

    task automatic test_single_link();
        set_config(64, 1);
        send_item(CMD_START, '1);
        send_item(CMD_DRAW, rand_word());
        set_config(64, 0);
        send_item(CMD_START, '0);
        send_item(CMD_DRAW, rand_word());
    endtask

    task automatic test_clique_extremes();
        int k;
        set_config(1024, 8);
        send_item(CMD_START, rand_word());
        for (k = 0; k < 3; k++)
            send_item(CMD_DRAW, rand_word());
        set_config(2047, 15);
        send_item(CMD_START, rand_word());
        send_item(CMD_DRAW, '1);
        send_item(CMD_DRAW, '0);
    endtask

    task automatic test_finish();
        int k;
        set_config(0, 2);
        send_item(CMD_START, rand_word());
        send_item(CMD_DRAW, rand_word());
        set_config(4, 2);
        send_item(CMD_START, rand_word());
        k = 0;
        while (node_now < nodes_eff() && k < 30)
        begin
            send_item(CMD_DRAW, rand_word());
            k++;
        end
        send_item(CMD_DRAW, rand_word());
        send_item(CMD_DRAW, '1);
    endtask

    task automatic test_random_phases();
        int p;
        int k;
        int lv;
        int nv;
        for (p = 0; p < 8; p++)
        begin
            case ($urandom_range(0, 7))
                0:       lv = 8;
                1:       lv = $urandom_range(0, 15);
                default: lv = $urandom_range(1, 4);
            endcase
            case ($urandom_range(0, 5))
                0:       nv = 1024;
                1:       nv = $urandom_range(0, 2047);
                default: nv = (lv == 0 ? 1 : (lv > 8 ? 8 : lv)) + $urandom_range(1, 8);
            endcase
            set_config(nv, lv);
            send_item(CMD_START, rand_word());
            for (k = 0; k < 50; k++)
            begin
                if (k == 25 || $urandom_range(0, 39) == 0)
                    drain();
                if ($urandom_range(0, 99) < 4)
                    send_item(CMD_START, rand_word());
                else
                    send_item(CMD_DRAW, rand_word());
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_draw_before_start();
        test_reset_defaults();
        test_single_link();
        test_clique_extremes();
        test_finish();
        test_random_phases();
        drain();
        repeat (60) @(posedge clk);
        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
